// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, command codes and the command type that passes from the
// front part to the back part.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_NUM_COLUMNS = 80;
    localparam int DEF_NUM_ROWS    = 25;

    localparam int CMD_COL_W   = 7;
    localparam int CMD_ROW_W   = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  CH_BACKSPACE = 8'd8;
    localparam logic [7:0]  CH_NEWLINE   = 8'd10;
    localparam logic [7:0]  CH_RETURN    = 8'd13;
    localparam logic [7:0]  CH_BLANK     = 8'h20;
    localparam logic [15:0] RESET_CELL   = 16'h0720;
    localparam logic [15:0] ERASED_CELL  = 16'h0020;
    localparam logic [7:0]  RESET_COLOR  = 8'd7;

    localparam logic [0:0]  REG_TEXT_COLOR = 1'b0;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_MOVE  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_BACKSPACE,
        OP_NEWLINE,
        OP_RETURN,
        OP_MOVE,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [7:0]           ch;
        logic [CMD_COL_W-1:0] col;
        logic [CMD_ROW_W-1:0] row;
    } t_cmd;

endpackage

// ===== hw/rtl/text_console_char_writer_top.sv =====
// ----------------------------------------------------------------------------
// Text console character writer
// Teletype-style text console: a screen store of character cells, a cursor,
// and an attribute register written over APB.
// ----------------------------------------------------------------------------
// After reset the block first blanks all NUM_COLUMNS*NUM_ROWS cells, one per
// cycle, and carries out no item until that is done; the command queue
// still takes up to two transfers in the meantime. Items pass through a
// two-entry command queue to the back part, which owns the screen memory. A
// move or return has its result registered straight from the idle state; a
// put does too unless it fills the last column of the last row and so starts
// a scroll, and a read first passes through the S_READ state for the
// registered memory read. A scroll copies every cell but the last row, a read
// and then a write per cell, and then fills the last row; a clear fills every
// cell. Each transfer returns exactly one result.
// ----------------------------------------------------------------------------
module text_console_char_writer_top
    import tcw_pkg::*;
#(
    parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
    parameter int NUM_ROWS    = DEF_NUM_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_column,
    input  logic [7:0]  i_row,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_cursor_column,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_address,
    output logic [15:0] o_cell_value
);

    logic [7:0] r_text_color;
    t_cmd       front_cmd;
    t_cmd       queue_cmd;
    logic       queue_full;
    logic       queue_valid;
    logic       queue_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TEXT_COLOR) ? {24'd0, r_text_color} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_COLOR;
        end else if (psel && penable && pwrite && (paddr == REG_TEXT_COLOR)) begin
            r_text_color <= pwdata[7:0];
        end
    end

    assign o_in_ready = !queue_full;

    tcw_front #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_front (
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_column    (i_column),
        .i_row       (i_row),
        .o_cmd       (front_cmd)
    );

    tcw_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !queue_full),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    tcw_back #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_text_color     (r_text_color),
        .i_cmd_valid      (queue_valid),
        .i_cmd            (queue_cmd),
        .o_cmd_pop        (queue_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cursor_column  (o_cursor_column),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_address (o_cursor_address),
        .o_cell_value     (o_cell_value)
    );

endmodule

// ===== hw/rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// Text console writer front
// Classifies an incoming item into a command and clamps its target position.
// ----------------------------------------------------------------------------
module tcw_front
    import tcw_pkg::*;
#(
    parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
    parameter int NUM_ROWS    = DEF_NUM_ROWS
) (
    input  logic [1:0] i_mode,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_column,
    input  logic [7:0] i_row,
    output t_cmd       o_cmd
);

    localparam logic [7:0] LAST_COL = 8'(NUM_COLUMNS - 1);
    localparam logic [7:0] LAST_ROW = 8'(NUM_ROWS - 1);

    logic [7:0] col_clamped;
    logic [7:0] row_clamped;

    assign col_clamped = (i_column > LAST_COL) ? LAST_COL : i_column;
    assign row_clamped = (i_row > LAST_ROW) ? LAST_ROW : i_row;

    always_comb begin
        o_cmd.ch  = i_char_code;
        o_cmd.col = col_clamped[CMD_COL_W-1:0];
        o_cmd.row = row_clamped[CMD_ROW_W-1:0];
        o_cmd.op  = OP_READ;
        unique case (t_mode'(i_mode))
            MODE_PUT: begin
                priority if (i_char_code == CH_BACKSPACE) begin
                    o_cmd.op = OP_BACKSPACE;
                end else if (i_char_code == CH_NEWLINE) begin
                    o_cmd.op = OP_NEWLINE;
                end else if (i_char_code == CH_RETURN) begin
                    o_cmd.op = OP_RETURN;
                end else begin
                    o_cmd.op = OP_CHAR;
                end
            end
            MODE_MOVE:  o_cmd.op = OP_MOVE;
            MODE_CLEAR: o_cmd.op = OP_CLEAR;
            MODE_READ:  o_cmd.op = OP_READ;
        endcase
    end

endmodule

// ===== hw/rtl/tcw_fifo.sv =====
// ----------------------------------------------------------------------------
// Text console writer command queue
// A short queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module tcw_fifo
    import tcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd        r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

// ===== hw/rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// Text console writer back
// Owns the cursor and the screen store, carries out commands and holds the
// result register.
// ----------------------------------------------------------------------------
module tcw_back
    import tcw_pkg::*;
#(
    parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
    parameter int NUM_ROWS    = DEF_NUM_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_text_color,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_cursor_column,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_address,
    output logic [15:0] o_cell_value
);

    localparam int CELLS = NUM_COLUMNS * NUM_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(NUM_COLUMNS);
    localparam int RW    = $clog2(NUM_ROWS);

    localparam logic [CW-1:0] LAST_COL   = CW'(NUM_COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(NUM_ROWS - 1);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_COPY  = AW'(CELLS - NUM_COLUMNS - 1);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(NUM_COLUMNS);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    logic [6:0]    r_out_col;
    logic [4:0]    r_out_row;
    logic [10:0]   r_out_addr;
    logic [15:0]   r_out_cell;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    logic          pop;
    logic          load;
    logic          load_cell;
    logic          new_line;
    logic [AW-1:0] cur_index;
    logic [AW-1:0] cmd_index;
    logic [AW-1:0] next_index;
    logic [15:0]   blank;

    function automatic logic [AW-1:0] cell_index(input logic [RW-1:0] row,
                                                 input logic [CW-1:0] col);
        cell_index = AW'(row) * ROW_STRIDE + AW'(col);
    endfunction

    assign blank      = {i_text_color, CH_BLANK};
    assign cur_index  = cell_index(r_row, r_col);
    assign cmd_index  = cell_index(RW'(i_cmd.row), CW'(i_cmd.col));
    assign next_index = cell_index(n_row, n_col);

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = blank;
        ram_raddr   = cmd_index;
        pop         = 1'b0;
        load        = 1'b0;
        load_cell   = 1'b0;
        new_line    = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = RESET_CELL;
                n_idx     = r_idx + 1'b1;
                if (r_idx == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && (!r_out_valid || i_out_ready)) begin
                    pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_CHAR: begin
                            ram_we    = 1'b1;
                            ram_waddr = cur_index;
                            ram_wdata = {i_text_color, i_cmd.ch};
                            if (r_col == LAST_COL) begin
                                new_line = 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                                load  = 1'b1;
                            end
                        end
                        OP_BACKSPACE: begin
                            if (r_col != '0) begin
                                ram_we    = 1'b1;
                                ram_waddr = cur_index;
                                ram_wdata = ERASED_CELL;
                                n_col     = r_col - 1'b1;
                            end
                            load = 1'b1;
                        end
                        OP_NEWLINE: begin
                            new_line = 1'b1;
                        end
                        OP_RETURN: begin
                            n_col = '0;
                            load  = 1'b1;
                        end
                        OP_MOVE: begin
                            n_col = CW'(i_cmd.col);
                            n_row = RW'(i_cmd.row);
                            load  = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_idx   = '0;
                            n_state = S_FILL;
                        end
                        OP_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                load      = 1'b1;
                load_cell = 1'b1;
                n_state   = S_IDLE;
            end
            S_SCR_RD: begin
                ram_raddr = r_idx + ROW_STRIDE;
                n_state   = S_SCR_WR;
            end
            S_SCR_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = r_idx + 1'b1;
                n_state   = (r_idx == LAST_COPY) ? S_FILL : S_SCR_RD;
            end
            S_FILL: begin
                ram_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == LAST_CELL) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (new_line) begin
            n_col = '0;
            if (r_row != LAST_ROW) begin
                n_row = r_row + 1'b1;
                load  = 1'b1;
            end else begin
                n_idx   = '0;
                n_state = S_SCR_RD;
            end
        end

        if (load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_col  <= 7'(n_col);
            r_out_row  <= 5'(n_row);
            r_out_addr <= 11'(next_index);
            r_out_cell <= load_cell ? ram_rdata : 16'd0;
        end
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd_pop        = pop;
    assign o_out_valid      = r_out_valid;
    assign o_cursor_column  = r_out_col;
    assign o_cursor_row     = r_out_row;
    assign o_cursor_address = r_out_addr;
    assign o_cell_value     = r_out_cell;

endmodule
